// ===== rtl/ssf_pkg.sv =====
// shared types and constants of the servo command framer
`timescale 1ns / 1ps

package ssf_pkg;

  localparam int unsigned SLOTS = 13;
  localparam int unsigned POS_SLOTS = 13;
  localparam int unsigned MOVE_SLOTS = 10;

  localparam logic PROTO_POS_SPEED = 1'b0;
  localparam logic PROTO_MOVE_TIME = 1'b1;

  localparam logic [7:0] POS_HEADER = 8'hFF;
  localparam logic [7:0] POS_LENGTH = 8'h09;
  localparam logic [7:0] POS_INSTR_WRITE = 8'h03;
  localparam logic [7:0] POS_START_ADDR = 8'h2A;
  localparam logic [7:0] ZERO_BYTE = 8'h00;

  localparam logic [7:0] MOVE_HEADER = 8'h55;
  localparam logic [7:0] MOVE_LENGTH = 8'h07;
  localparam logic [7:0] MOVE_COMMAND = 8'h01;

  typedef struct packed {
    logic       vld;
    logic       last;
    logic [7:0] data;
  } ssf_slot_t;

endpackage

// ===== rtl/serial_servo_command_framer.sv =====
// servo command framer: one command in, its serial packet out byte by byte
//
// usage:
//   s_axis carries one command per transfer; tuser[0] selects the protocol
//   (0 = 13-byte position/speed write, 1 = 10-byte move-time write) and
//   tdata holds servo id, position and speed or time, low fields first.
//   m_axis carries one packet byte per transfer, tlast marks the checksum.
//   a command is loaded in parallel into a row of 13 byte cells; every
//   cycle the downstream side takes a byte the row moves one cell closer
//   to the output, so the row itself is the output register.
//   latency: the first byte is offered the cycle after the command transfer.
//   throughput: one byte per cycle leaves the cell row while the receiver
//   is ready; a new command is taken in the same cycle the checksum byte
//   leaves, so packets follow each other with no gap.
//   reset clears the valid and last flags of every cell; the row comes up empty and ready.
//   when the receiver stalls the row holds still and no new command is
//   taken until only the final byte remains and is being taken.
`timescale 1ns / 1ps

module serial_servo_command_framer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,   // target_id[7:0], position[23:8], speed_or_time[39:24]
  input  logic        s_axis_tuser_i,   // protocol[0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // out_byte[7:0]
  output logic        m_axis_tlast_o
);

  ssf_pkg::ssf_slot_t [ssf_pkg::SLOTS-1:0] load_slots;
  ssf_pkg::ssf_slot_t [ssf_pkg::SLOTS-1:0] slot_w;
  ssf_pkg::ssf_slot_t [ssf_pkg::SLOTS-1:0] next_w;
  logic s_accept, m_accept, load, shift;

  ssf_packer u_packer (
    .protocol_i      (s_axis_tuser_i),
    .target_id_i     (s_axis_tdata_i[7:0]),
    .position_i      (s_axis_tdata_i[23:8]),
    .speed_or_time_i (s_axis_tdata_i[39:24]),
    .slots_o         (load_slots)
  );

  // ready once at most the head cell is full and it leaves this cycle
  assign s_axis_tready_o = !slot_w[1].vld && (!slot_w[0].vld || m_axis_tready_i);
  assign s_accept = s_axis_tvalid_i && s_axis_tready_o;
  assign m_accept = m_axis_tvalid_o && m_axis_tready_i;
  assign load     = s_accept;
  assign shift    = m_axis_tready_i || !slot_w[0].vld;

  for (genvar g = 0; g < ssf_pkg::SLOTS; g++) begin : g_cells
    if (g == ssf_pkg::SLOTS - 1) begin : g_tail
      assign next_w[g] = '0;
    end else begin : g_body
      assign next_w[g] = slot_w[g+1];
    end
    ssf_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .load_i      (load),
      .shift_i     (shift),
      .load_slot_i (load_slots[g]),
      .next_slot_i (next_w[g]),
      .slot_o      (slot_w[g])
    );
  end

  assign m_axis_tvalid_o = slot_w[0].vld;
  assign m_axis_tdata_o  = slot_w[0].data;
  assign m_axis_tlast_o  = slot_w[0].last;

  a_accept_offers_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept |=> m_axis_tvalid_o && !m_axis_tlast_o &&
      (m_axis_tdata_o == ($past(s_axis_tuser_i) ? ssf_pkg::MOVE_HEADER
                                                : ssf_pkg::POS_HEADER)))
    else $error("header byte not offered after command transfer");

  a_cells_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_w[1].vld |-> slot_w[0].vld && !slot_w[0].last)
    else $error("gap or early last in cell row");

  a_drained_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_accept && m_axis_tlast_o && !s_accept) |=> !m_axis_tvalid_o)
    else $error("byte offered after checksum without a new command");

  a_ready_only_when_draining: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_accept && m_axis_tvalid_o) |-> m_accept && m_axis_tlast_o)
    else $error("command taken while packet bytes remain");

endmodule

// ===== rtl/ssf_cell.sv =====
// one byte cell of the output shift chain
`timescale 1ns / 1ps

module ssf_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  logic              shift_i,
  input  ssf_pkg::ssf_slot_t load_slot_i,
  input  ssf_pkg::ssf_slot_t next_slot_i,
  output ssf_pkg::ssf_slot_t slot_o
);

  logic       vld_q, vld_d;
  logic       last_q, last_d;
  logic [7:0] data_q, data_d;

  always_comb begin
    vld_d  = vld_q;
    last_d = last_q;
    data_d = data_q;
    if (load_i) begin
      vld_d  = load_slot_i.vld;
      last_d = load_slot_i.last;
      data_d = load_slot_i.data;
    end else if (shift_i) begin
      vld_d  = next_slot_i.vld;
      last_d = next_slot_i.last;
      data_d = next_slot_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      last_q <= 1'b0;
    end else begin
      vld_q  <= vld_d;
      last_q <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign slot_o = '{vld: vld_q, last: last_q, data: data_q};

endmodule

// ===== rtl/ssf_packer.sv =====
// builds the packet bytes and checksum of one command for a parallel load
`timescale 1ns / 1ps

module ssf_packer (
  input  logic                                    protocol_i,
  input  logic [7:0]                              target_id_i,
  input  logic [15:0]                             position_i,
  input  logic [15:0]                             speed_or_time_i,
  output ssf_pkg::ssf_slot_t [ssf_pkg::SLOTS-1:0] slots_o
);

  logic [7:0] pos_sum, move_sum;
  logic [7:0] bytes [ssf_pkg::SLOTS];
  logic [3:0] count;

  // modulo 256 sums from the id byte up to the last payload byte
  assign pos_sum = target_id_i + ssf_pkg::POS_LENGTH + ssf_pkg::POS_INSTR_WRITE
                 + ssf_pkg::POS_START_ADDR + position_i[7:0] + position_i[15:8]
                 + speed_or_time_i[7:0] + speed_or_time_i[15:8];
  assign move_sum = target_id_i + ssf_pkg::MOVE_LENGTH + ssf_pkg::MOVE_COMMAND
                  + position_i[7:0] + position_i[15:8]
                  + speed_or_time_i[7:0] + speed_or_time_i[15:8];

  always_comb begin
    for (int i = 0; i < ssf_pkg::SLOTS; i++) begin
      bytes[i] = ssf_pkg::ZERO_BYTE;
    end
    case (protocol_i)
      ssf_pkg::PROTO_POS_SPEED: begin
        count     = 4'(ssf_pkg::POS_SLOTS);
        bytes[0]  = ssf_pkg::POS_HEADER;
        bytes[1]  = ssf_pkg::POS_HEADER;
        bytes[2]  = target_id_i;
        bytes[3]  = ssf_pkg::POS_LENGTH;
        bytes[4]  = ssf_pkg::POS_INSTR_WRITE;
        bytes[5]  = ssf_pkg::POS_START_ADDR;
        bytes[6]  = position_i[7:0];
        bytes[7]  = position_i[15:8];
        bytes[8]  = ssf_pkg::ZERO_BYTE;
        bytes[9]  = ssf_pkg::ZERO_BYTE;
        bytes[10] = speed_or_time_i[7:0];
        bytes[11] = speed_or_time_i[15:8];
        bytes[12] = ~pos_sum;
      end
      ssf_pkg::PROTO_MOVE_TIME: begin
        count    = 4'(ssf_pkg::MOVE_SLOTS);
        bytes[0] = ssf_pkg::MOVE_HEADER;
        bytes[1] = ssf_pkg::MOVE_HEADER;
        bytes[2] = target_id_i;
        bytes[3] = ssf_pkg::MOVE_LENGTH;
        bytes[4] = ssf_pkg::MOVE_COMMAND;
        bytes[5] = position_i[7:0];
        bytes[6] = position_i[15:8];
        bytes[7] = speed_or_time_i[7:0];
        bytes[8] = speed_or_time_i[15:8];
        bytes[9] = ~move_sum;
      end
      default: begin
        count = '0;
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < ssf_pkg::SLOTS; i++) begin
      slots_o[i].vld  = (4'(i) < count);
      slots_o[i].last = (4'(i) == count - 4'd1);
      slots_o[i].data = bytes[i];
    end
  end

endmodule

// ===== sim/serial_servo_command_framer_test.sv =====
// self-checking testbench of the servo command framer: commands in, packet bytes checked
`timescale 1ns / 1ps

module serial_servo_command_framer_test;

  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } packet_byte_t;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [39:0] s_axis_tdata_i  = '0;   // target_id[7:0], position[23:8], speed_or_time[39:24]
  logic        s_axis_tuser_i  = 1'b0; // protocol[0]
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [7:0]  m_axis_tdata_o;         // out_byte[7:0]
  logic        m_axis_tlast_o;

  packet_byte_t expected_bytes_q[$];
  int unsigned  error_count   = 0;
  int unsigned  stall_cycles  = 0;
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_idle_pct = 0;

  always #5 clk_i = ~clk_i;

  serial_servo_command_framer dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // builds the packet of one command and queues its bytes in transmission order
  function automatic void frame_command(input logic proto, input logic [7:0] id,
                                        input logic [15:0] pos, input logic [15:0] sot);
    logic [7:0] pkt [ssf_pkg::SLOTS];
    logic [7:0] sum;
    int         count;
    sum = '0;
    if (proto == ssf_pkg::PROTO_POS_SPEED) begin
      pkt[0]  = ssf_pkg::POS_HEADER;
      pkt[1]  = ssf_pkg::POS_HEADER;
      pkt[2]  = id;
      pkt[3]  = ssf_pkg::POS_LENGTH;
      pkt[4]  = ssf_pkg::POS_INSTR_WRITE;
      pkt[5]  = ssf_pkg::POS_START_ADDR;
      pkt[6]  = pos[7:0];
      pkt[7]  = pos[15:8];
      pkt[8]  = ssf_pkg::ZERO_BYTE;
      pkt[9]  = ssf_pkg::ZERO_BYTE;
      pkt[10] = sot[7:0];
      pkt[11] = sot[15:8];
      count   = int'(ssf_pkg::POS_SLOTS);
    end else begin
      pkt[0] = ssf_pkg::MOVE_HEADER;
      pkt[1] = ssf_pkg::MOVE_HEADER;
      pkt[2] = id;
      pkt[3] = ssf_pkg::MOVE_LENGTH;
      pkt[4] = ssf_pkg::MOVE_COMMAND;
      pkt[5] = pos[7:0];
      pkt[6] = pos[15:8];
      pkt[7] = sot[7:0];
      pkt[8] = sot[15:8];
      count  = int'(ssf_pkg::MOVE_SLOTS);
    end
    // sum wraps at 8 bits, id byte through last payload byte
    for (int i = 2; i < count - 1; i++) sum = sum + pkt[i];
    pkt[count - 1] = ~sum;
    for (int i = 0; i < count; i++)
      expected_bytes_q.push_back('{value: pkt[i], last: logic'(i == count - 1)});
  endfunction

  function automatic logic [15:0] pick_word();
    case ($urandom_range(7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [7:0] pick_id();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'hFE;
      default: return 8'($urandom());
    endcase
  endfunction

  // offers one command, idling first at random, and waits for its transfer
  task automatic send_command(input logic proto, input logic [7:0] id,
                              input logic [15:0] pos, input logic [15:0] sot);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= {8'($urandom()), 32'($urandom())};
      s_axis_tuser_i  <= 1'($urandom());
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {sot, pos, id};
    s_axis_tuser_i  <= proto;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    frame_command(proto, id, pos, sot);
  endtask

  task automatic test_field_extremes();
    for (int p = 0; p < 2; p++) begin
      send_command(1'(p), 8'h00, 16'h0000, 16'h0000);
      send_command(1'(p), 8'hFF, 16'hFFFF, 16'hFFFF);
      send_command(1'(p), 8'hFE, 16'h1234, 16'hABCD);
      send_command(1'(p), 8'h01, 16'h00FF, 16'hFF00);
      send_command(1'(p), 8'h80, 16'h8000, 16'h0001);
    end
  endtask

  // ids chosen so the byte sum lands exactly on 0xff and on a wrap to 0x00
  task automatic test_checksum_wrap();
    send_command(ssf_pkg::PROTO_POS_SPEED, 8'hCA, 16'h0000, 16'h0000);
    send_command(ssf_pkg::PROTO_POS_SPEED, 8'hC9, 16'h0000, 16'h0000);
    send_command(ssf_pkg::PROTO_MOVE_TIME, 8'hF8, 16'h0000, 16'h0000);
    send_command(ssf_pkg::PROTO_MOVE_TIME, 8'hF7, 16'h0000, 16'h0000);
  endtask

  task automatic test_random_commands(input int unsigned count);
    for (int unsigned n = 0; n < count; n++)
      send_command(1'($urandom()), pick_id(), pick_word(), pick_word());
  endtask

  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin : check_output
    packet_byte_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_bytes_q.size() == 0) begin
        $display("%0t: unexpected byte, expected none, got %02h last %0b",
                 $time, m_axis_tdata_o, m_axis_tlast_o);
        error_count++;
      end else begin
        want = expected_bytes_q.pop_front();
        if (m_axis_tdata_o !== want.value || m_axis_tlast_o !== want.last) begin
          $display("%0t: byte mismatch, expected %02h last %0b, got %02h last %0b",
                   $time, want.value, want.last, m_axis_tdata_o, m_axis_tlast_o);
          error_count++;
        end
      end
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 9;
    recv_idle_pct = 80;
    test_field_extremes();
    test_checksum_wrap();
    test_random_commands(39);

    send_idle_pct = 80;
    recv_idle_pct = 9;
    test_random_commands(39);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_commands(38);

    s_axis_tvalid_i <= 1'b0;
    while (expected_bytes_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_count == 0 && expected_bytes_q.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
